// ===== design/bcc_pkg.sv =====
`default_nettype none

package bcc_pkg;

    localparam int unsigned TIME_W     = 16;
    localparam int unsigned TICK_W     = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned EVENT_W    = 2;
    localparam int unsigned CLICKS_W   = 2;

    typedef logic [TIME_W-1:0]     time_t;
    typedef logic [TICK_W-1:0]     tick_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_index_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [CLICKS_W-1:0]   clicks_t;

    typedef enum logic [3:0] {
        PH_RELEASED = 4'b0001,
        PH_PRESSED  = 4'b0010,
        PH_HOLDING  = 4'b0100,
        PH_LONG     = 4'b1000
    } phase_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    localparam cfg_index_t CFG_ACTIVE_LEVEL    = 3'd0;
    localparam cfg_index_t CFG_TICK_MS         = 3'd1;
    localparam cfg_index_t CFG_DEBOUNCE_MS     = 3'd2;
    localparam cfg_index_t CFG_LONG_PRESS_MS   = 3'd3;
    localparam cfg_index_t CFG_DOUBLE_CLICK_MS = 3'd4;

    localparam logic  RST_ACTIVE_LEVEL    = 1'b0;
    localparam tick_t RST_TICK_MS         = 8'd5;
    localparam tick_t RST_DEBOUNCE_MS     = 8'd20;
    localparam time_t RST_LONG_PRESS_MS   = 16'd5000;
    localparam time_t RST_DOUBLE_CLICK_MS = 16'd500;

    // add one tick to a duration, holding at full scale
    function automatic time_t sat_add(input time_t a, input tick_t b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {{(TIME_W + 1 - TICK_W){1'b0}}, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/bcc_channels.sv =====
`default_nettype none

interface bcc_sample_if;
    logic valid;
    logic ready;
    logic level;

    modport source (output valid, output level, input ready);
    modport sink   (input valid, input level, output ready);
endinterface

interface bcc_result_if;
    logic                         valid;
    logic                         ready;
    logic [bcc_pkg::EVENT_W-1:0]  event_res;

    modport source (output valid, output event_res, input ready);
    modport sink   (input valid, input event_res, output ready);
endinterface

`default_nettype wire

// ===== design/button_click_classifier_unit.sv =====
// channel   dir   payload              request accepted when
// sample    in    level (1 bit)        valid && ready
// result    out   event_res (2 bits)   valid && ready
// cfg       in    cfg_index, cfg_data  cfg_we high
//
// one sample per cycle while ready is high; its event is registered into the result register, or into the skid
// the classifier state is updated in the same cycle the sample is taken
// a two-entry output buffer (result register plus skid) keeps input ready
// for one more sample while a result stalls; ready drops only when both are full
// rst_n resets the state machine, counters, config registers and buffer flags at once; event registers are not reset
`default_nettype none

module button_click_classifier_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    bcc_sample_if.sink                 sample,
    bcc_result_if.source               result,
    input  wire logic                  cfg_we,
    input  wire bcc_pkg::cfg_index_t   cfg_index,
    input  wire bcc_pkg::cfg_data_t    cfg_data
);

    logic              active_level_reg;
    bcc_pkg::tick_t    tick_ms_reg;
    bcc_pkg::tick_t    debounce_ms_reg;
    bcc_pkg::time_t    long_press_ms_reg;
    bcc_pkg::time_t    double_click_ms_reg;

    bcc_pkg::phase_t   phase_reg, phase_next;
    bcc_pkg::time_t    press_time_reg, press_time_next;
    bcc_pkg::time_t    release_time_reg, release_time_next;
    bcc_pkg::clicks_t  clicks_reg, clicks_next;
    bcc_pkg::event_t   ev;

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    bcc_pkg::event_t   out_event_reg, out_event_next;
    bcc_pkg::event_t   skid_event_reg, skid_event_next;

    logic              accept;
    logic              take;
    logic              down;
    bcc_pkg::time_t    press_inc;
    bcc_pkg::time_t    release_inc;
    bcc_pkg::clicks_t  clicks_inc;

    assign sample.ready     = !skid_valid_reg;
    assign accept           = sample.valid && sample.ready;
    assign take             = out_valid_reg && result.ready;
    assign result.valid     = out_valid_reg;
    assign result.event_res = out_event_reg;

    assign down        = (sample.level == active_level_reg);
    assign press_inc   = bcc_pkg::sat_add(press_time_reg, tick_ms_reg);
    assign release_inc = bcc_pkg::sat_add(release_time_reg, tick_ms_reg);
    assign clicks_inc  = clicks_reg + bcc_pkg::clicks_t'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg    <= bcc_pkg::RST_ACTIVE_LEVEL;
            tick_ms_reg         <= bcc_pkg::RST_TICK_MS;
            debounce_ms_reg     <= bcc_pkg::RST_DEBOUNCE_MS;
            long_press_ms_reg   <= bcc_pkg::RST_LONG_PRESS_MS;
            double_click_ms_reg <= bcc_pkg::RST_DOUBLE_CLICK_MS;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bcc_pkg::CFG_ACTIVE_LEVEL:    active_level_reg    <= cfg_data[0];
                bcc_pkg::CFG_TICK_MS:         tick_ms_reg         <= cfg_data[7:0];
                bcc_pkg::CFG_DEBOUNCE_MS:     debounce_ms_reg     <= cfg_data[7:0];
                bcc_pkg::CFG_LONG_PRESS_MS:   long_press_ms_reg   <= cfg_data;
                bcc_pkg::CFG_DOUBLE_CLICK_MS: double_click_ms_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        phase_next        = phase_reg;
        press_time_next   = press_time_reg;
        release_time_next = release_time_reg;
        clicks_next       = clicks_reg;
        ev                = bcc_pkg::EV_NONE;

        unique case (phase_reg)
            bcc_pkg::PH_RELEASED:
            begin
                if (down)
                begin
                    phase_next      = bcc_pkg::PH_PRESSED;
                    press_time_next = '0;
                end
                else if (clicks_reg == bcc_pkg::clicks_t'(1))
                begin
                    release_time_next = release_inc;
                    if (release_inc >= double_click_ms_reg)
                    begin
                        ev                = bcc_pkg::EV_SINGLE;
                        clicks_next       = '0;
                        release_time_next = '0;
                    end
                end
            end
            bcc_pkg::PH_PRESSED:
            begin
                if (down)
                begin
                    press_time_next = press_inc;
                    if (press_inc >= bcc_pkg::time_t'(debounce_ms_reg))
                        phase_next = bcc_pkg::PH_HOLDING;
                end
                else
                begin
                    phase_next      = bcc_pkg::PH_RELEASED;
                    press_time_next = '0;
                end
            end
            bcc_pkg::PH_HOLDING:
            begin
                if (down)
                begin
                    press_time_next = press_inc;
                    if (press_inc >= long_press_ms_reg)
                    begin
                        ev          = bcc_pkg::EV_LONG;
                        phase_next  = bcc_pkg::PH_LONG;
                        clicks_next = '0;
                    end
                end
                else
                begin
                    // short press only; too short or too long is dropped silently
                    if (press_time_reg >= bcc_pkg::time_t'(debounce_ms_reg) &&
                        press_time_reg < long_press_ms_reg)
                    begin
                        clicks_next       = clicks_inc;
                        release_time_next = '0;
                        if (clicks_inc == bcc_pkg::clicks_t'(2))
                        begin
                            ev          = bcc_pkg::EV_DOUBLE;
                            clicks_next = '0;
                        end
                    end
                    phase_next      = bcc_pkg::PH_RELEASED;
                    press_time_next = '0;
                end
            end
            bcc_pkg::PH_LONG:
            begin
                if (!down)
                begin
                    phase_next      = bcc_pkg::PH_RELEASED;
                    press_time_next = '0;
                end
            end
            default:
            begin
                phase_next      = bcc_pkg::PH_RELEASED;
                press_time_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= bcc_pkg::PH_RELEASED;
            press_time_reg   <= '0;
            release_time_reg <= '0;
            clicks_reg       <= '0;
        end
        else if (accept)
        begin
            phase_reg        <= phase_next;
            press_time_reg   <= press_time_next;
            release_time_reg <= release_time_next;
            clicks_reg       <= clicks_next;
        end
    end

    // skid is empty whenever a request is accepted
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_event_next  = out_event_reg;
        skid_event_next = skid_event_reg;
        priority if (accept)
        begin
            if (!out_valid_reg || take)
            begin
                out_valid_next = 1'b1;
                out_event_next = ev;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_event_next = ev;
            end
        end
        else if (take)
        begin
            if (skid_valid_reg)
            begin
                out_event_next  = skid_event_reg;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
        else
        begin
            // buffer holds
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_event_reg  <= out_event_next;
        skid_event_reg <= skid_event_next;
    end

    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a result in the output register");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
        else $error("accepted request produced no pending result");

    a_clicks_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        clicks_reg == bcc_pkg::clicks_t'(0) || clicks_reg == bcc_pkg::clicks_t'(1))
        else $error("pending click count out of range");

    a_long_clears_clicks: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bcc_pkg::PH_LONG |-> clicks_reg == '0)
        else $error("click still pending during a long press");

    a_released_no_press_time: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == bcc_pkg::PH_RELEASED |-> press_time_reg == '0)
        else $error("press time not cleared while released");

endmodule

`default_nettype wire
